// ===== src/dlg_pkg.sv =====
package dlg_pkg;

  localparam int COORD_BITS = 6;
  localparam int ERR_BITS = COORD_BITS + 3;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } seg_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last;
  } pix_out_t;

  // One normalized segment, as handed from the classifier to the stepper.
  typedef struct packed {
    logic                  y_major;
    logic                  step_neg;
    logic                  inclusive;
    logic [COORD_BITS-1:0] major_len;
    logic [COORD_BITS-1:0] minor_len;
    logic [COORD_BITS-1:0] major_start;
    logic [COORD_BITS-1:0] minor_start;
  } seg_cmd_t;

endpackage

// ===== src/dlg_front.sv =====
module dlg_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  dlg_pkg::seg_in_t  in_data,
  input  logic              queue_full,
  output logic              push,
  output dlg_pkg::seg_cmd_t cmd
);
  import dlg_pkg::*;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS:0]        ax_w;
  logic [COORD_BITS:0]        ay_w;
  logic [COORD_BITS-1:0]      ax;
  logic [COORD_BITS-1:0]      ay;
  logic                       dx_zero;
  logic                       dy_zero;
  logic                       same;
  logic                       y_major;

  always_comb begin
    dx = $signed({1'b0, in_data.end_x}) - $signed({1'b0, in_data.start_x});
    dy = $signed({1'b0, in_data.end_y}) - $signed({1'b0, in_data.start_y});
    ax_w = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
    ay_w = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
    ax = ax_w[COORD_BITS-1:0];
    ay = ay_w[COORD_BITS-1:0];
    dx_zero = (dx == '0);
    dy_zero = (dy == '0);
    same = !dx_zero && !dy_zero && (dx[COORD_BITS] == dy[COORD_BITS]);

    cmd = '0;
    if ((ay <= ax) && same) begin
      y_major = 1'b0;
      cmd.step_neg = 1'b0;
      cmd.inclusive = 1'b0;
    end else if ((ay > ax) && (same || dx_zero)) begin
      y_major = 1'b1;
      cmd.step_neg = 1'b0;
      cmd.inclusive = 1'b1;
    end else if (ay >= ax) begin
      y_major = 1'b1;
      cmd.step_neg = 1'b1;
      cmd.inclusive = 1'b0;
    end else begin
      y_major = 1'b0;
      cmd.step_neg = 1'b1;
      cmd.inclusive = 1'b1;
    end
    cmd.y_major = y_major;

    if (y_major) begin
      cmd.major_len = ay;
      cmd.minor_len = ax;
      if (in_data.start_y < in_data.end_y) begin
        cmd.major_start = in_data.start_y;
        cmd.minor_start = in_data.start_x;
      end else begin
        cmd.major_start = in_data.end_y;
        cmd.minor_start = in_data.end_x;
      end
    end else begin
      cmd.major_len = ax;
      cmd.minor_len = ay;
      if (in_data.start_x < in_data.end_x) begin
        cmd.major_start = in_data.start_x;
        cmd.minor_start = in_data.start_y;
      end else begin
        cmd.major_start = in_data.end_x;
        cmd.minor_start = in_data.end_y;
      end
    end
  end

  assign in_stall = queue_full;
  assign push = in_valid && !queue_full;

endmodule

// ===== src/dlg_queue.sv =====
module dlg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dlg_pkg::seg_cmd_t push_data,
  input  logic              pop,
  output dlg_pkg::seg_cmd_t pop_data,
  output logic              full,
  output logic              empty
);
  import dlg_pkg::*;

  localparam int PtrBits = $clog2(QUEUE_DEPTH);

  seg_cmd_t             slot_r [QUEUE_DEPTH];
  logic [PtrBits-1:0]   wr_ptr_r;
  logic [PtrBits-1:0]   wr_ptr_nxt;
  logic [PtrBits-1:0]   rd_ptr_r;
  logic [PtrBits-1:0]   rd_ptr_nxt;
  logic [PtrBits:0]     count_r;
  logic [PtrBits:0]     count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full = (count_r == (PtrBits+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/dlg_back.sv =====
module dlg_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               queue_empty,
  input  dlg_pkg::seg_cmd_t  cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output dlg_pkg::pix_out_t  out_data
);
  import dlg_pkg::*;

  logic                        busy_r;
  logic                        busy_nxt;
  logic [COORD_BITS-1:0]       remain_r;
  logic [COORD_BITS-1:0]       remain_nxt;
  logic [COORD_BITS-1:0]       major_r;
  logic [COORD_BITS-1:0]       major_nxt;
  logic [COORD_BITS-1:0]       minor_r;
  logic [COORD_BITS-1:0]       minor_nxt;
  logic signed [ERR_BITS-1:0]  err_r;
  logic signed [ERR_BITS-1:0]  err_nxt;
  logic signed [ERR_BITS-1:0]  inc_step_r;
  logic signed [ERR_BITS-1:0]  inc_step_nxt;
  logic signed [ERR_BITS-1:0]  inc_flat_r;
  logic signed [ERR_BITS-1:0]  inc_flat_nxt;
  logic                        y_major_r;
  logic                        y_major_nxt;
  logic                        step_neg_r;
  logic                        step_neg_nxt;
  logic                        inclusive_r;
  logic                        inclusive_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  pix_out_t                    out_data_r;
  pix_out_t                    out_data_nxt;
  logic                        fire;
  logic                        step_minor;
  logic signed [ERR_BITS-1:0]  minor2;
  logic signed [ERR_BITS-1:0]  major2;

  assign fire = busy_r && (!out_valid_r || !out_stall);
  assign pop = !busy_r && !queue_empty;
  assign step_minor = inclusive_r ? !err_r[ERR_BITS-1]
                                  : (!err_r[ERR_BITS-1] && (err_r != '0));

  always_comb begin
    minor2 = $signed({2'b00, cmd.minor_len, 1'b0});
    major2 = $signed({2'b00, cmd.major_len, 1'b0});

    busy_nxt = busy_r;
    remain_nxt = remain_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    err_nxt = err_r;
    inc_step_nxt = inc_step_r;
    inc_flat_nxt = inc_flat_r;
    y_major_nxt = y_major_r;
    step_neg_nxt = step_neg_r;
    inclusive_nxt = inclusive_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (pop) begin
      busy_nxt = 1'b1;
      remain_nxt = cmd.major_len;
      major_nxt = cmd.major_start;
      minor_nxt = cmd.minor_start;
      err_nxt = minor2 - $signed({3'b000, cmd.major_len});
      inc_step_nxt = minor2 - major2;
      inc_flat_nxt = minor2;
      y_major_nxt = cmd.y_major;
      step_neg_nxt = cmd.step_neg;
      inclusive_nxt = cmd.inclusive;
    end else if (fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt.pixel_x = y_major_r ? minor_r : major_r;
      out_data_nxt.pixel_y = y_major_r ? major_r : minor_r;
      out_data_nxt.last = (remain_r == '0);
      if (step_minor) begin
        minor_nxt = step_neg_r ? minor_r - 1'b1 : minor_r + 1'b1;
        err_nxt = err_r + inc_step_r;
      end else begin
        err_nxt = err_r + inc_flat_r;
      end
      major_nxt = major_r + 1'b1;
      remain_nxt = remain_r - 1'b1;
      if (remain_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    remain_r <= remain_nxt;
    major_r <= major_nxt;
    minor_r <= minor_nxt;
    err_r <= err_nxt;
    inc_step_r <= inc_step_nxt;
    inc_flat_r <= inc_flat_nxt;
    y_major_r <= y_major_nxt;
    step_neg_r <= step_neg_nxt;
    inclusive_r <= inclusive_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

// ===== src/digital_line_2d_generator.sv =====
// Line rasterizer: one input transaction carries two endpoints, and the block
// returns every pixel of the digital segment between them, one pixel per
// output transaction, with last set on the final pixel of the segment.
// Both channels use valid and stall; a transaction completes on a clock edge
// where valid is high and stall is low.
// A classifier works out the octant, extents and start point of each segment
// as it is taken and writes it into a two-entry queue. A stepper pulls one
// segment at a time from the queue and walks the decision variable, one pixel
// per cycle while the output is not stalled, into an output register.
// Each segment passes through the queue slot and the stepper registers before
// its first pixel reaches the output register. A segment whose major extent
// is n gives n + 1 pixels, so up to 64 pixels per segment.
// Inputs are taken while the queue has room, so up to two segments can wait
// behind the one being drawn.
// A stalled output holds its pixel and freezes the stepper; the queue then
// fills and in_stall rises. Reset empties the queue, drops any segment in
// progress and clears out_valid; no state is kept between segments.
module digital_line_2d_generator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dlg_pkg::seg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output dlg_pkg::pix_out_t out_data
);
  import dlg_pkg::*;

  seg_cmd_t push_cmd;
  seg_cmd_t pop_cmd;
  logic     push;
  logic     pop;
  logic     queue_full;
  logic     queue_empty;

  dlg_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  dlg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  dlg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_empty (queue_empty),
    .cmd         (pop_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
